### sv/tpsm_pkg.sv
// Shared types, constants and signature tables for the TCP payload signature matcher.
`default_nettype none

package tpsm_pkg;

  // Frame layout offsets, in bytes from the start of the Ethernet frame.
  localparam int ETH_LEN      = 14;
  localparam int IP_PROTO_POS = ETH_LEN + 9;
  localparam int TCP_OFF_REL  = 12;
  localparam int MIN_IP_LEN   = 20;
  localparam int MIN_FRAME    = 34;

  localparam logic [7:0] TCP_PROTO   = 8'd6;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Signature set. Each text is right-justified, so that character j counted
  // from the end of the signature sits in byte j of the vector.
  localparam int NUM_SIGS    = 8;
  localparam int SIG_MAX_LEN = 13;
  localparam int SIG_IDX_W   = $clog2(NUM_SIGS);
  localparam int SIG_LEN_W   = $clog2(SIG_MAX_LEN + 1);

  localparam logic [SIG_MAX_LEN*8-1:0] SIG_TEXT [NUM_SIGS] = '{
    "union select",
    "drop table",
    "select * from",
    "etc/passwd",
    "bin/sh",
    "cmd.exe",
    "' or '1'='1",
    "' or 1=1"
  };

  localparam logic [SIG_LEN_W-1:0] SIG_LEN [NUM_SIGS] = '{
    SIG_LEN_W'(12), SIG_LEN_W'(10), SIG_LEN_W'(13), SIG_LEN_W'(10),
    SIG_LEN_W'(6),  SIG_LEN_W'(7),  SIG_LEN_W'(11), SIG_LEN_W'(8)
  };

  // Depth of the queue between the classifier and the matcher.
  localparam int FIFO_DEPTH = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_CLEAN   = 2'd1,
    ST_MATCHED = 2'd2
  } status_t;

  // What the matcher does with a byte.
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_STEP    = 2'd1,
    MODE_RESOLVE = 2'd2
  } mode_t;

  // One classified byte, passed from the classifier to the matcher.
  typedef struct packed {
    logic [7:0]           lc_byte;   // lower-cased frame byte
    mode_t                mode;
    logic [SIG_LEN_W-1:0] pbs;       // payload bytes in the window, capped at SIG_MAX_LEN
    logic                 last;
    logic                 eligible;  // frame qualifies for a clean or matched verdict
  } tpsm_word_t;

endpackage

`default_nettype wire

### sv/tcp_payload_signature_matcher_unit.sv
// Top level of the TCP payload signature matcher: classifier, queue and matcher.
// Throughput is one frame byte per cycle unless in_stall is set; the window comparators work in parallel on each byte.
// The result word for a frame is registered: its last byte is first written into the queue, and
// the matcher loads the result register when it pops that byte, once any earlier result is taken.
// Bytes that are not last flow through even while a result waits to be taken.
// Synchronous reset clears the frame state, the queue and the result valid; no clearing pass.
`default_nettype none

module tcp_payload_signature_matcher_unit import tpsm_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535,
  parameter int WINDOW_BYTES    = 13
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           frame_byte,
  input  wire logic                 last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [SIG_IDX_W-1:0]      signature_index
);

  logic       take;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  tpsm_word_t front_word;
  tpsm_word_t q_head;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // Header parsing and byte classification.
  tpsm_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .WINDOW_BYTES   (WINDOW_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .frame_byte(frame_byte),
    .last      (last),
    .word      (front_word)
  );

  // Queue between the two halves.
  tpsm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_word(front_word),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_valid),
    .full     (q_full)
  );

  // Signature matching and result.
  tpsm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .word           (q_head),
    .word_valid     (q_valid),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .signature_index(signature_index)
  );

  // A signature index is only reported together with a match.
  a_index_only_on_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_MATCHED)) |-> (signature_index == '0))
    else $error("signature index set without a match");

  // Reset leaves no result pending and the input open.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("reset did not clear the handshake state");

  // A queued word stays queued until the matcher takes it.
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued word lost before the matcher took it");

  // A frame result only follows a final word leaving the queue.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_pop && q_head.last))
    else $error("result without a final word");

endmodule

`default_nettype wire

### sv/tpsm_front.sv
// Header parser and classifier: tracks the frame position and tags each byte.
`default_nettype none

module tpsm_front import tpsm_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535,
  parameter int WINDOW_BYTES    = 13
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] frame_byte,
  input  wire logic       last,
  output tpsm_word_t      word
);

  localparam int PW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int PBW = $clog2(WINDOW_BYTES + 1);
  localparam int CW  = (PW > 8) ? PW : 8;

  logic [PW-1:0]  pos, pos_next;
  logic [5:0]     ip_hb, ip_hb_next;
  logic [5:0]     tcp_hb, tcp_hb_next;
  logic           is_tcp, is_tcp_next;
  logic           hdr_known, hdr_known_next;
  logic [PBW-1:0] pbs, pbs_next;

  logic           sat;
  logic           resolved;
  logic [CW-1:0]  pos_c;
  logic [CW-1:0]  start_c;
  logic [CW-1:0]  run_c;
  mode_t          mode;

  // Decode the header fields and work out the payload state for this byte.
  always_comb begin
    sat            = (pos == PW'(MAX_FRAME_BYTES));
    pos_c          = CW'(pos);
    pos_next       = pos;
    ip_hb_next     = ip_hb;
    tcp_hb_next    = tcp_hb;
    is_tcp_next    = is_tcp;
    hdr_known_next = hdr_known;
    resolved       = 1'b0;
    pbs_next       = pbs;
    mode           = MODE_NONE;
    run_c          = '0;

    if (!sat) begin
      pos_next = pos + PW'(1);
      if (pos_c == CW'(ETH_LEN)) begin
        ip_hb_next = {frame_byte[3:0], 2'b00};
      end else if (pos_c == CW'(IP_PROTO_POS)) begin
        is_tcp_next = (frame_byte == TCP_PROTO);
      end else if (pos_c == CW'(ETH_LEN + TCP_OFF_REL) + CW'(ip_hb)) begin
        tcp_hb_next    = {frame_byte[7:4], 2'b00};
        hdr_known_next = 1'b1;
        resolved       = 1'b1;
      end
    end

    start_c = CW'(ETH_LEN) + CW'(ip_hb_next) + CW'(tcp_hb_next);

    // A short data offset can place the payload start at or before this byte.
    if (resolved && start_c <= pos_c) begin
      run_c    = pos_c - start_c + CW'(1);
      pbs_next = PBW'(run_c);
      mode     = MODE_RESOLVE;
    end else if (hdr_known_next && (sat || pos_c >= start_c)) begin
      if (pbs != PBW'(WINDOW_BYTES)) begin
        pbs_next = pbs + PBW'(1);
      end
      mode = MODE_STEP;
    end
  end

  // Word for the matcher.
  always_comb begin
    word.lc_byte = ((frame_byte >= CHAR_UPPER_A) && (frame_byte <= CHAR_UPPER_Z)) ?
                   frame_byte + CASE_OFFSET : frame_byte;
    word.mode    = mode;
    word.pbs     = (pbs_next >= PBW'(SIG_MAX_LEN)) ? SIG_LEN_W'(SIG_MAX_LEN) :
                   SIG_LEN_W'(pbs_next);
    word.last    = last;
    word.eligible = (CW'(pos_next) >= CW'(MIN_FRAME)) && is_tcp_next &&
                    (CW'(pos_next) >= CW'(ETH_LEN + MIN_IP_LEN) + CW'(ip_hb_next)) &&
                    hdr_known_next && (pbs_next != '0);
  end

  // Frame state; the last byte of a frame returns everything to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ip_hb     <= '0;
      tcp_hb    <= '0;
      is_tcp    <= 1'b0;
      hdr_known <= 1'b0;
      pbs       <= '0;
    end else if (take) begin
      if (last) begin
        pos       <= '0;
        ip_hb     <= '0;
        tcp_hb    <= '0;
        is_tcp    <= 1'b0;
        hdr_known <= 1'b0;
        pbs       <= '0;
      end else begin
        pos       <= pos_next;
        ip_hb     <= ip_hb_next;
        tcp_hb    <= tcp_hb_next;
        is_tcp    <= is_tcp_next;
        hdr_known <= hdr_known_next;
        pbs       <= pbs_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/tpsm_fifo.sv
// Short queue of classified words between the classifier and the matcher.
`default_nettype none

module tpsm_fifo import tpsm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire tpsm_word_t push_word,
  input  wire logic       pop,
  output tpsm_word_t      head,
  output logic            not_empty,
  output logic            full
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  tpsm_word_t    entries [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == NW'(FIFO_DEPTH));

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/tpsm_back.sv
// Signature matcher: byte window, per-byte match history, found flags and result register.
`default_nettype none

module tpsm_back import tpsm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tpsm_word_t           word,
  input  wire logic                 word_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [SIG_IDX_W-1:0]      signature_index
);

  logic [7:0]          wnd  [SIG_MAX_LEN-1];
  logic [NUM_SIGS-1:0] hist [SIG_MAX_LEN-1];
  logic [7:0]          view [SIG_MAX_LEN];
  logic [NUM_SIGS-1:0] hview [SIG_MAX_LEN];
  logic [NUM_SIGS-1:0] m0;
  logic [NUM_SIGS-1:0] step_hits;
  logic [NUM_SIGS-1:0] res_hits;
  logic [NUM_SIGS-1:0] found, found_next;
  logic [SIG_IDX_W-1:0] first_idx;
  status_t             verdict;

  // A non-final word never blocks; a final word waits for the result register.
  assign pop = word_valid && (!word.last || !out_valid || !out_stall);

  // Window view with the newest byte at position zero.
  always_comb begin
    view[0]  = word.lc_byte;
    hview[0] = m0;
    for (int j = 1; j < SIG_MAX_LEN; j++) begin
      view[j]  = wnd[j-1];
      hview[j] = hist[j-1];
    end
  end

  // Compare every signature ending at the newest byte.
  always_comb begin
    for (int s = 0; s < NUM_SIGS; s++) begin
      m0[s] = 1'b1;
      for (int j = 0; j < SIG_MAX_LEN; j++) begin
        if ((j < int'(SIG_LEN[s])) && (view[j] != SIG_TEXT[s][j*8 +: 8])) begin
          m0[s] = 1'b0;
        end
      end
    end
  end

  // A hit counts only when the whole signature lies inside the payload.
  // When the payload start is found late, earlier end positions come from the history.
  always_comb begin
    for (int s = 0; s < NUM_SIGS; s++) begin
      step_hits[s] = m0[s] && (SIG_LEN[s] <= word.pbs);
      res_hits[s]  = 1'b0;
      for (int k = 0; k < SIG_MAX_LEN; k++) begin
        if (hview[k][s] && (k + int'(SIG_LEN[s]) <= int'(word.pbs))) begin
          res_hits[s] = 1'b1;
        end
      end
    end
  end

  // Update the found flags.
  always_comb begin
    case (word.mode)
      MODE_STEP:    found_next = found | step_hits;
      MODE_RESOLVE: found_next = found | res_hits;
      default:      found_next = found;
    endcase
  end

  // Lowest-indexed signature found, and the verdict for the frame.
  always_comb begin
    first_idx = '0;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      if (found_next[s]) begin
        first_idx = SIG_IDX_W'(s);
      end
    end
    if (!word.eligible) begin
      verdict = ST_IGNORED;
    end else if (found_next != '0) begin
      verdict = ST_MATCHED;
    end else begin
      verdict = ST_CLEAN;
    end
  end

  // Byte window and match history shift once per word.
  always_ff @(posedge clk) begin
    if (pop) begin
      wnd[0]  <= word.lc_byte;
      hist[0] <= m0;
      for (int j = 1; j < SIG_MAX_LEN - 1; j++) begin
        wnd[j]  <= wnd[j-1];
        hist[j] <= hist[j-1];
      end
    end
  end

  // Found flags are cleared at the end of every frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= '0;
    end else if (pop) begin
      found <= word.last ? '0 : found_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && word.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && word.last) begin
      status          <= verdict;
      signature_index <= (verdict == ST_MATCHED) ? first_idx : '0;
    end
  end

endmodule

`default_nettype wire
